>>> hdl/pdrg_pkg.sv
package pdrg_pkg;

	// field widths fixed by the item format
	localparam int FUNC_W   = 2;
	localparam int SECS_W   = 16;
	localparam int SAMPLE_W = 10;
	localparam int EVENT_W  = 4;
	localparam int THR_W    = 10;
	localparam int MS_W     = 20;
	localparam int RUN_W    = 26;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;

	localparam logic [RUN_W-1:0] MS_PER_S = RUN_W'(1000);

	// register reset values
	localparam logic [THR_W-1:0] RISE_THRESHOLD_RST  = THR_W'(50);
	localparam logic [MS_W-1:0]  CHECK_PERIOD_RST    = MS_W'(11000);
	localparam logic [MS_W-1:0]  MIN_WAIT_RST        = MS_W'(3000);

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 2'd0,
		FN_START = 2'd1,
		FN_STOP  = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE    = 4'd0,
		EV_STARTED = 4'd1,
		EV_BUSY    = 4'd2,
		EV_BLOCKED = 4'd3,
		EV_TIMED   = 4'd4,
		EV_DRY     = 4'd5,
		EV_CMD     = 4'd6,
		EV_FLOW    = 4'd7,
		EV_CLEARED = 4'd8
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_THRESHOLD = 2'd0,
		REG_CHECK_PERIOD   = 2'd1,
		REG_MIN_WAIT       = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [SECS_W-1:0]   run_seconds;
		logic [SAMPLE_W-1:0] moisture;
	} in_item_t;

	typedef struct packed {
		logic               pump_on;
		logic               emergency;
		logic [EVENT_W-1:0] event_res;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0] rise_threshold;
		logic [MS_W-1:0]  check_period_ms;
		logic [MS_W-1:0]  hold_off_ms;
	} cfg_t;

endpackage

>>> hdl/pdrg_cfg_regs.sv
module pdrg_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdrg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdrg_pkg::CFG_W-1:0]         cfg_data,
	output pdrg_pkg::cfg_t                     cfg
);
	import pdrg_pkg::*;

	cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold  <= RISE_THRESHOLD_RST;
			cfg_q.check_period_ms <= CHECK_PERIOD_RST;
			cfg_q.hold_off_ms     <= MIN_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RISE_THRESHOLD: cfg_q.rise_threshold  <= cfg_data[THR_W-1:0];
				REG_CHECK_PERIOD:   cfg_q.check_period_ms <= cfg_data[MS_W-1:0];
				REG_MIN_WAIT:       cfg_q.hold_off_ms     <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/pdrg_core.sv
module pdrg_core #(
	parameter int ADC_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdrg_pkg::in_item_t  item,
	input  logic                advance,
	input  pdrg_pkg::cfg_t      cfg,
	output pdrg_pkg::out_item_t res
);
	import pdrg_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic                running;
		logic                latch;
		logic [RUN_W-1:0]    elapsed;
		logic [RUN_W-1:0]    length;
		logic [MS_W-1:0]     timer;
		logic [MS_W-1:0]     since;
		phase_t              phase;
		logic [SAMPLE_W-1:0] baseline;
	} ctl_state_t;

	ctl_state_t st_q;
	ctl_state_t nxt;
	event_t     ev;

	logic [SAMPLE_W-1:0] mask;
	logic [SAMPLE_W-1:0] sample;
	logic [RUN_W-1:0]    elapsed_inc;
	logic [MS_W-1:0]     timer_inc;
	logic [MS_W-1:0]     since_inc;
	logic                flow_pass;

	// pump off with all run counters cleared
	function automatic ctl_state_t halted(ctl_state_t s);
		ctl_state_t r;
		r         = s;
		r.running = 1'b0;
		r.elapsed = '0;
		r.length  = '0;
		r.timer   = '0;
		r.since   = '0;
		r.phase   = PH_IDLE;
		return r;
	endfunction

	// only the low converter bits count
	always_comb begin
		for (int i = 0; i < SAMPLE_W; i++) begin
			mask[i] = (i < ADC_BITS);
		end
	end
	assign sample = item.moisture & mask;

	// saturating counters
	assign elapsed_inc = (&st_q.elapsed) ? st_q.elapsed : st_q.elapsed + 1'b1;
	assign timer_inc   = (st_q.phase == PH_WAIT && !(&st_q.timer)) ? st_q.timer + 1'b1
	                                                                 : st_q.timer;
	assign since_inc   = (st_q.phase == PH_WAIT && !(&st_q.since)) ? st_q.since + 1'b1
	                                                                 : st_q.since;

	// flow check: waited long enough and the rise reaches the threshold
	assign flow_pass = (since_inc >= cfg.hold_off_ms) &&
		({1'b0, sample} >= ({1'b0, st_q.baseline} + {1'b0, cfg.rise_threshold}));

	// next state and event for the item
	always_comb begin
		nxt = st_q;
		ev  = EV_NONE;
		case (item.func)
			FN_START: begin
				if (st_q.running) begin
					ev = EV_BUSY;
				end else if (st_q.latch) begin
					ev = EV_BLOCKED;
				end else begin
					nxt.baseline = sample;
					nxt.since    = '0;
					nxt.timer    = '0;
					nxt.phase    = PH_WAIT;
					nxt.running  = 1'b1;
					nxt.elapsed  = '0;
					nxt.length   = RUN_W'(item.run_seconds) * MS_PER_S;
					ev           = EV_STARTED;
				end
			end
			FN_STOP: begin
				if (st_q.running) begin
					nxt = halted(st_q);
					ev  = EV_CMD;
				end
			end
			FN_CLEAR: begin
				if (st_q.latch) begin
					nxt.latch = 1'b0;
					ev        = EV_CLEARED;
				end
			end
			FN_TICK: begin
				if (st_q.running) begin
					nxt.elapsed = elapsed_inc;
					nxt.timer   = timer_inc;
					nxt.since   = since_inc;
					if (st_q.length != '0 && elapsed_inc >= st_q.length) begin
						nxt = halted(st_q);
						ev  = EV_TIMED;
					end else if (st_q.phase == PH_WAIT &&
					             timer_inc >= cfg.check_period_ms) begin
						if (flow_pass) begin
							ev = EV_FLOW;
							if (st_q.length != '0) begin
								nxt.phase = PH_DONE;
							end else begin
								nxt.baseline = sample;
								nxt.since    = '0;
								nxt.timer    = '0;
								nxt.phase    = PH_WAIT;
							end
						end else begin
							nxt       = halted(st_q);
							nxt.latch = 1'b1;
							ev        = EV_DRY;
						end
					end
				end
			end
			default: ;
		endcase
	end

	// controller state commits when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.running  <= 1'b0;
			st_q.latch    <= 1'b0;
			st_q.elapsed  <= '0;
			st_q.length   <= '0;
			st_q.timer    <= '0;
			st_q.since    <= '0;
			st_q.phase    <= PH_IDLE;
			st_q.baseline <= '0;
		end else if (advance) begin
			st_q <= nxt;
		end
	end

	assign res.pump_on   = nxt.running;
	assign res.emergency = nxt.latch;
	assign res.event_res = ev;

endmodule

>>> hdl/pump_dry_run_guard.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_stall | in_data: func, run_seconds, moisture
// output   | out_valid/out_stall | out_data: pump_on, emergency, event_res
// config   | cfg_we              | cfg_index, cfg_data (no read-back)
//
// one item per clock when the output is not stalled; items pass through the
// input register, then the result register
// the controller state updates in the same cycle as the result register
// arst_n clears the pipeline valids, the controller state and the registers
// an output stall holds the result; the input stalls only when both stages are full
module pump_dry_run_guard #(
	parameter int ADC_BITS = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  pdrg_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output pdrg_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [pdrg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdrg_pkg::CFG_W-1:0]        cfg_data
);
	import pdrg_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid_q;
	out_item_t res_q;
	out_item_t res;
	cfg_t      cfg;
	logic      advance;

	// item moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	pdrg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdrg_core #(
		.ADC_BITS (ADC_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.cfg     (cfg),
		.res     (res)
	);

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// the pump never runs with the emergency latch set
	a_no_run_in_emergency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.pump_on && out_data.emergency))
		else $error("pump on while emergency latched");

	// a start always leaves the pump running
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.event_res == EV_STARTED) |-> out_data.pump_on)
		else $error("start reported with pump off");

	// a dry stop latches the emergency and drops the relay
	a_dry_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.event_res == EV_DRY) |->
			(out_data.emergency && !out_data.pump_on))
		else $error("dry stop without emergency latch");

	// the input stalls only while both stages hold an item and the output is stalled
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdrg_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_PRINTS  = 100;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 40;

	typedef enum logic [1:0] {
		CHK_IDLE = 2'd0,
		CHK_WAIT = 2'd1,
		CHK_DONE = 2'd2
	} chk_phase_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_data;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	pump_dry_run_guard dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// guard state as the block should hold it
	logic              pump_run;
	logic              dry_latch;
	logic [RUN_W-1:0]  run_ms;
	logic [RUN_W-1:0]  run_limit_ms;
	logic [MS_W-1:0]   chk_ms;
	logic [MS_W-1:0]   since_base_ms;
	chk_phase_t        chk_phase;
	logic [SAMPLE_W-1:0] base_level;
	logic [THR_W-1:0]  thr_cfg;
	logic [MS_W-1:0]   period_cfg;
	logic [MS_W-1:0]   wait_cfg;

	// pump status items still owed by the block, oldest first
	out_item_t status_q[$];

	int          errors = 0;
	int unsigned quiet = 0;
	int unsigned stall_left = 0;
	int unsigned calm_left = 0;
	logic        calm = 1'b0;
	logic        valid_up = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void stop_pump();
		pump_run      = 1'b0;
		run_ms        = '0;
		run_limit_ms  = '0;
		chk_ms        = '0;
		since_base_ms = '0;
		chk_phase     = CHK_IDLE;
	endfunction

	function automatic void new_baseline(logic [SAMPLE_W-1:0] sample);
		base_level    = sample;
		since_base_ms = '0;
		chk_ms        = '0;
		chk_phase     = CHK_WAIT;
	endfunction

	function automatic void guard_reset();
		thr_cfg    = RISE_THRESHOLD_RST;
		period_cfg = CHECK_PERIOD_RST;
		wait_cfg   = MIN_WAIT_RST;
		dry_latch  = 1'b0;
		base_level = '0;
		stop_pump();
	endfunction

	// moisture rise big enough, and not too soon after the baseline
	function automatic logic flow_seen(logic [SAMPLE_W-1:0] sample);
		if (since_base_ms < wait_cfg)
			return 1'b0;
		return (int'(sample) - int'(base_level)) >= int'(thr_cfg);
	endfunction

	// next pump status for one accepted item
	function automatic out_item_t guard_step(in_item_t it);
		event_t    ev;
		out_item_t res;
		ev = EV_NONE;
		case (it.func)
			FN_START: begin
				if (pump_run) begin
					ev = EV_BUSY;
				end else if (dry_latch) begin
					ev = EV_BLOCKED;
				end else begin
					new_baseline(it.moisture);
					pump_run     = 1'b1;
					run_ms       = '0;
					run_limit_ms = RUN_W'(it.run_seconds) * MS_PER_S;
					ev           = EV_STARTED;
				end
			end
			FN_STOP: begin
				if (pump_run) begin
					stop_pump();
					ev = EV_CMD;
				end
			end
			FN_CLEAR: begin
				if (dry_latch) begin
					dry_latch = 1'b0;
					ev        = EV_CLEARED;
				end
			end
			FN_TICK: begin
				if (pump_run) begin
					if (run_ms != '1)
						run_ms = run_ms + 1'b1;
					if (chk_phase == CHK_WAIT) begin
						if (chk_ms != '1)
							chk_ms = chk_ms + 1'b1;
						if (since_base_ms != '1)
							since_base_ms = since_base_ms + 1'b1;
					end
					// timed end beats a check due on the same tick
					if (run_limit_ms != '0 && run_ms >= run_limit_ms) begin
						stop_pump();
						ev = EV_TIMED;
					end else if (chk_phase == CHK_WAIT && chk_ms >= period_cfg) begin
						if (flow_seen(it.moisture)) begin
							ev = EV_FLOW;
							if (run_limit_ms != '0)
								chk_phase = CHK_DONE;
							else
								new_baseline(it.moisture);
						end else begin
							dry_latch = 1'b1;
							stop_pump();
							ev = EV_DRY;
						end
					end
				end
			end
			default: ;
		endcase
		res.pump_on   = pump_run;
		res.emergency = dry_latch;
		res.event_res = ev;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (errors < MAX_PRINTS)
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// gap after an item: none in calm stretches, mostly short otherwise
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(in_item_t it);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data  <= it;
		valid_up = 1'b1;
		do @(posedge clk); while (in_stall);
		status_q.push_back(guard_step(it));
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(func_t f, logic [SECS_W-1:0] secs, logic [SAMPLE_W-1:0] level);
		in_item_t it;
		it.func        = f;
		it.run_seconds = secs;
		it.moisture    = level;
		send_item(it);
	endtask

	// hold the sender until every owed status has come back
	task automatic drain();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(logic [THR_W-1:0] thr, logic [MS_W-1:0] period,
			logic [MS_W-1:0] min_wait);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_RISE_THRESHOLD;
		cfg_data  <= CFG_W'(thr);
		@(posedge clk);
		cfg_index <= REG_CHECK_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_index <= REG_MIN_WAIT;
		cfg_data  <= min_wait;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_cfg    = thr;
		period_cfg = period;
		wait_cfg   = min_wait;
	endtask

	// random item, mostly well-formed runs with moisture near the threshold
	function automatic in_item_t next_item();
		in_item_t    it;
		int unsigned r;
		int          level;
		it.func        = FN_TICK;
		it.run_seconds = SECS_W'($urandom_range(0, 65535));
		it.moisture    = SAMPLE_W'($urandom_range(0, 1023));
		r = $urandom_range(0, 99);
		if (pump_run) begin
			if (r < 86) begin
				if ($urandom_range(0, 9) != 0) begin
					level = int'(base_level) + int'(thr_cfg) + int'($urandom_range(0, 8)) - 4;
					if (level < 0)
						level = 0;
					if (level > 1023)
						level = 1023;
					it.moisture = SAMPLE_W'(level);
				end
			end else if (r < 90) begin
				it.func = FN_STOP;
			end else if (r < 94) begin
				it.func = FN_START;
			end else begin
				it.func = FUNC_W'($urandom_range(0, 3));
			end
		end else begin
			if (dry_latch && r < 60) begin
				it.func = FN_CLEAR;
			end else if (r < 80) begin
				it.func = FN_START;
				r = $urandom_range(0, 9);
				if (r < 7)
					it.run_seconds = '0;
				else if (r < 9)
					it.run_seconds = SECS_W'(1);
			end else begin
				it.func = FUNC_W'($urandom_range(0, 3));
			end
		end
		return it;
	endfunction

	// commands that do nothing while the pump is off
	task automatic test_stopped_cases();
		send_fields(FN_TICK, '0, '0);
		send_fields(FN_TICK, '1, '1);
		send_fields(FN_STOP, '0, SAMPLE_W'(512));
		send_fields(FN_CLEAR, '0, SAMPLE_W'(512));
	endtask

	// start, busy and command stop under reset settings
	task automatic test_start_stop();
		send_fields(FN_START, '1, '1);
		send_fields(FN_START, '0, '0);
		send_fields(FN_TICK, '0, '0);
		send_fields(FN_STOP, '0, '0);
		send_fields(FN_TICK, '0, '0);
	endtask

	// falling moisture and a check too early both latch the emergency
	task automatic test_dry_run();
		load_settings(THR_W'(50), MS_W'(3), '0);
		send_fields(FN_START, '0, SAMPLE_W'(1000));
		repeat (3) send_fields(FN_TICK, '0, SAMPLE_W'(10));
		send_fields(FN_START, '0, SAMPLE_W'(10));
		send_fields(FN_STOP, '0, SAMPLE_W'(10));
		send_fields(FN_TICK, '0, SAMPLE_W'(10));
		send_fields(FN_CLEAR, '0, SAMPLE_W'(10));
		send_fields(FN_CLEAR, '0, SAMPLE_W'(10));
		load_settings('0, MS_W'(2), MS_W'(5));
		send_fields(FN_START, '0, SAMPLE_W'(100));
		repeat (2) send_fields(FN_TICK, '0, SAMPLE_W'(900));
		send_fields(FN_CLEAR, '0, '0);
	endtask

	// zero check period checks on every tick; largest threshold
	task automatic test_zero_period();
		load_settings('0, '0, '0);
		send_fields(FN_START, '0, SAMPLE_W'(500));
		send_fields(FN_TICK, '0, SAMPLE_W'(500));
		send_fields(FN_TICK, '0, SAMPLE_W'(600));
		send_fields(FN_STOP, '0, '0);
		load_settings('1, '0, '0);
		send_fields(FN_START, '0, '0);
		send_fields(FN_TICK, '0, '1);
		send_fields(FN_TICK, '0, '1);
		send_fields(FN_CLEAR, '0, '0);
	endtask

	// one-second run ending on the check tick, then a timed run that checks once
	task automatic test_timed_runs();
		load_settings('0, MS_W'(1000), '0);
		send_fields(FN_START, SECS_W'(1), SAMPLE_W'(300));
		repeat (1000) send_fields(FN_TICK, '0, SAMPLE_W'($urandom_range(0, 1023)));
		load_settings('0, MS_W'(10), '0);
		send_fields(FN_START, SECS_W'(1), '0);
		repeat (30) send_fields(FN_TICK, '0, SAMPLE_W'($urandom_range(0, 1023)));
		send_fields(FN_STOP, '0, '0);
	endtask

	// random phases, each under its own settings, extremes included
	task automatic test_random_runs();
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == 0)
				load_settings('0, MS_W'(1), '0);
			else if (p == RAND_PHASES - 1)
				load_settings('1, MS_W'(600000), MS_W'(600000));
			else
				load_settings(THR_W'($urandom_range(0, 40)), MS_W'($urandom_range(1, 25)),
					MS_W'($urandom_range(0, 20)));
			repeat (PHASE_ITEMS) send_item(next_item());
		end
	endtask

	// stretches with no idling on either side
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm      <= ~calm;
			calm_left <= $urandom_range(20, 150);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// receiver stall, mostly short with an occasional long hold
	always @(posedge clk) begin : stall_gen
		int unsigned r;
		r = $urandom_range(0, 99);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (calm || r < 70) begin
			out_stall <= 1'b0;
		end else if (r < 96) begin
			out_stall <= 1'b1;
		end else begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(10, 30);
		end
	end

	// compare each status item with the oldest one owed
	always @(posedge clk) begin : status_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				report_mismatch("item with none owed", 1, 0);
			end else begin
				want = status_q.pop_front();
				if (out_data.pump_on !== want.pump_on)
					report_mismatch("pump_on", out_data.pump_on, want.pump_on);
				if (out_data.emergency !== want.emergency)
					report_mismatch("emergency", out_data.emergency, want.emergency);
				if (out_data.event_res !== want.event_res)
					report_mismatch("event_res", out_data.event_res, want.event_res);
			end
		end
	end

	// cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_RISE_THRESHOLD;
		cfg_data  <= '0;
		guard_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stopped_cases();
		test_start_stop();
		test_dry_run();
		test_zero_period();
		test_timed_runs();
		test_random_runs();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
